/* src/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_SIZE = 128;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int SLOT_W     = 7;
  localparam int STATUS_W   = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CHECK
  } seq_state_t;

  typedef struct packed {
    logic en;
    idx_t idx;
    key_t key;
    val_t value;
  } store_wr_t;

  typedef struct packed {
    logic used;
    key_t key;
    val_t value;
  } store_rd_t;

endpackage

/* src/lpht_if.sv */
// ----------------------------------------------------------------------------
// lpht_req_if / lpht_rsp_if
// Valid/ready channels for requests into and results out of the hash table.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] key;
  logic [31:0] entry_value;

  modport source (output valid, output cmd, output key, output entry_value, input ready);
  modport sink (input valid, input cmd, input key, input entry_value, output ready);
endinterface

interface lpht_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [6:0]  slot;
  logic [31:0] found_value;
  logic [1:0]  status;

  modport source (output valid, output hit, output slot, output found_value, output status,
                  input ready);
  modport sink (input valid, input hit, input slot, input found_value, input status,
                output ready);
endinterface

/* src/linear_probe_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing over TABLE_SIZE slots.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request is accepted in S_IDLE, and
// each slot it probes passes through S_PROBE, which reads the slot memory,
// and S_CHECK, which compares the registered data; a request probes from
// one to TABLE_SIZE slots. A lookup stops at a matching key or at an empty
// slot, an insert at the first empty slot; after TABLE_SIZE probes the result
// is not found or table full. The result sits in an output register, so the
// next request is accepted while the previous result waits to be taken. The
// valid map is cleared by reset and needs no clearing pass.
module linear_probe_hash_table_unit (
  input logic        clk,
  input logic        rst_n,
  lpht_req_if.sink   in_req,
  lpht_rsp_if.source out_rsp
);
  import lpht_pkg::*;

  seq_state_t state_r, state_nxt;
  logic       cmd_r, cmd_nxt;
  key_t       key_r, key_nxt;
  val_t       val_r, val_nxt;
  idx_t       idx_r, idx_nxt;
  idx_t       cnt_r, cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  val_t              out_val_r, out_val_nxt;
  status_t           out_status_r, out_status_nxt;

  logic      rd_en;
  store_rd_t rd_q;
  store_wr_t wr;
  logic      out_free;
  logic      done;
  logic      res_hit;
  logic [SLOT_W-1:0] res_slot;
  val_t      res_val;
  status_t   res_status;
  logic      do_write;

  lpht_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_idx (idx_r),
    .rd_q   (rd_q),
    .wr     (wr)
  );

  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    rd_en      = 1'b0;
    in_req.ready = 1'b0;
    done       = 1'b0;
    do_write   = 1'b0;
    res_hit    = 1'b0;
    res_slot   = '0;
    res_val    = '0;
    res_status = STAT_OK;
    case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          cmd_nxt   = in_req.cmd;
          key_nxt   = in_req.key;
          val_nxt   = in_req.entry_value;
          idx_nxt   = in_req.key[IDX_W-1:0];
          cnt_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        rd_en     = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!rd_q.used) begin
          done = 1'b1;
          if (cmd_r == CMD_INSERT) begin
            do_write = 1'b1;
            res_hit  = 1'b1;
            res_slot = SLOT_W'(idx_r);
          end else begin
            res_status = STAT_NOT_FOUND;
          end
        end else if (cmd_r == CMD_LOOKUP && rd_q.key == key_r) begin
          done     = 1'b1;
          res_hit  = 1'b1;
          res_slot = SLOT_W'(idx_r);
          res_val  = rd_q.value;
        end else if (cnt_r == IDX_W'(TABLE_SIZE - 1)) begin
          done       = 1'b1;
          res_status = (cmd_r == CMD_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_PROBE;
        end
        if (done && out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign wr.en    = do_write && out_free;
  assign wr.idx   = idx_r;
  assign wr.key   = key_r;
  assign wr.value = val_r;

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;
    out_val_nxt    = out_val_r;
    out_status_nxt = out_status_r;
    if (done && out_free) begin
      out_valid_nxt  = 1'b1;
      out_hit_nxt    = res_hit;
      out_slot_nxt   = res_slot;
      out_val_nxt    = res_val;
      out_status_nxt = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_val_r    <= out_val_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.hit         = out_hit_r;
  assign out_rsp.slot        = out_slot_r;
  assign out_rsp.found_value = out_val_r;
  assign out_rsp.status      = out_status_r;

endmodule

/* src/lpht_store.sv */
// ----------------------------------------------------------------------------
// lpht_store
// Slot storage: a valid map cleared by reset and a key/value memory with one
// registered read port and one write port.
// ----------------------------------------------------------------------------
module lpht_store (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  lpht_pkg::idx_t     rd_idx,
  output lpht_pkg::store_rd_t rd_q,
  input  lpht_pkg::store_wr_t wr
);
  import lpht_pkg::*;

  logic [TABLE_SIZE-1:0]    used_r;
  logic [KEY_W+VAL_W-1:0]   mem [TABLE_SIZE];
  logic                     used_q_r;
  logic [KEY_W+VAL_W-1:0]   data_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr.en) begin
      used_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= {wr.key, wr.value};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_q_r <= mem[rd_idx];
      used_q_r <= used_r[rd_idx];
    end
  end

  assign rd_q.used  = used_q_r;
  assign rd_q.key   = data_q_r[KEY_W+VAL_W-1:VAL_W];
  assign rd_q.value = data_q_r[VAL_W-1:0];

endmodule

/* src/lpht_checker.sv */
// ----------------------------------------------------------------------------
// lpht_assertions
// Port-level checks on the result channel of the hash table unit.
// ----------------------------------------------------------------------------
module lpht_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [6:0]  out_slot,
  input logic [31:0] out_found_value,
  input logic [1:0]  out_status
);
  import lpht_pkg::*;

  // A held result keeps its slot and status until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_status))
    else $error("result item changed while stalled");

  // Hit and an ok status always go together.
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_status == STAT_OK)))
    else $error("hit disagrees with status");

  // A failed request reports slot zero and no value.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_slot == '0 && out_found_value == '0)
    else $error("failed request carries slot or value");

  // No result item is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind linear_probe_hash_table_unit lpht_assertions u_lpht_assertions (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_hit         (out_rsp.hit),
  .out_slot        (out_rsp.slot),
  .out_found_value (out_rsp.found_value),
  .out_status      (out_rsp.status)
);

/* dv/lpht_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the request and result channels of the hash table unit, keeps its
// own copy of the slot table to work out each result, and compares every
// result taken from the block with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lpht_req_if  req,
  lpht_rsp_if  rsp,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    val_t              found_value;
    status_t           status;
  } probe_outcome_t;

  logic           slot_used [TABLE_SIZE];
  key_t           slot_key  [TABLE_SIZE];
  val_t           slot_val  [TABLE_SIZE];
  probe_outcome_t outcome_q [$];

  function automatic probe_outcome_t probe_table(input cmd_t op, input key_t k,
                                                 input val_t v);
    probe_outcome_t o;
    int             pos;
    o   = '0;
    pos = int'(k % KEY_W'(TABLE_SIZE));
    if (op == CMD_LOOKUP) begin
      o.status = STAT_NOT_FOUND;
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (!slot_used[pos]) break;
        if (slot_key[pos] == k) begin
          o.hit         = 1'b1;
          o.slot        = SLOT_W'(pos);
          o.found_value = slot_val[pos];
          o.status      = STAT_OK;
          break;
        end
        pos = (pos + 1) % TABLE_SIZE;
      end
    end else begin
      o.status = STAT_FULL;
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (!slot_used[pos]) begin
          slot_used[pos] = 1'b1;
          slot_key[pos]  = k;
          slot_val[pos]  = v;
          o.hit          = 1'b1;
          o.slot         = SLOT_W'(pos);
          o.status       = STAT_OK;
          break;
        end
        pos = (pos + 1) % TABLE_SIZE;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    probe_outcome_t want;
    int             bad;
    bad = 0;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SIZE; i++) slot_used[i] = 1'b0;
      outcome_q.delete();
      fail_count <= 0;
    end else begin
      if (req.valid && req.ready) begin
        outcome_q.push_back(probe_table(cmd_t'(req.cmd), req.key, req.entry_value));
      end
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected result: hit %0d slot %0d status %0d",
                 rsp.hit, rsp.slot, rsp.status);
          bad++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, rsp.hit);
            bad++;
          end
          if (rsp.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, rsp.slot);
            bad++;
          end
          if (rsp.found_value !== want.found_value) begin
            $error("found_value: expected %h, actual %h", want.found_value,
                   rsp.found_value);
            bad++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            bad++;
          end
        end
      end
      fail_count <= fail_count + bad;
    end
    pending_count <= outcome_q.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives lookups and inserts into the hash table unit in random bursts while
// the result side stalls on its own pattern, fills the table until it is
// full, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import lpht_pkg::*;

  localparam int NUM_RANDOM = 1300;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_LEN   = 600;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   items_sent = 0;
  int   burst_left = 0;
  key_t key_pool [$];

  lpht_req_if req ();
  lpht_rsp_if rsp ();

  linear_probe_hash_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req),
    .out_rsp(rsp)
  );

  lpht_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(input cmd_t op, input key_t k, input val_t v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 40);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    req.valid       <= 1'b1;
    req.cmd         <= op;
    req.key         <= k;
    req.entry_value <= v;
    do @(posedge clk); while (!req.ready);
    burst_left--;
    items_sent++;
    if (op == CMD_INSERT) key_pool.push_back(k);
  endtask

  function automatic key_t pool_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  initial begin
    key_t k;
    int   r;
    rst_n           <= 1'b0;
    req.valid       <= 1'b0;
    req.cmd         <= CMD_LOOKUP;
    req.key         <= '0;
    req.entry_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, wrap-around past the last slot, duplicates and misses
    // that walk a chain of occupied slots.
    send_request(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h0000_00FF, 32'hA5A5_5A5A);
    send_request(CMD_LOOKUP, 32'h0000_00FF, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_request(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 32'h0000_0080, 32'h0000_0000);
    send_request(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_request(CMD_INSERT, 32'h8000_0000, 32'h8000_0001);
    send_request(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(CMD_LOOKUP, 32'h5555_5555, 32'h5555_5555);
    send_request(CMD_LOOKUP, 32'hFFFF_FF7F, 32'h0000_0000);

    // About one item in eight is an insert; the inserts fill the table part
    // way through, so the later items run against a full table.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      r = $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0) begin
        if (r < 2) k = pool_key();
        else if (r < 6) k = ($urandom() & ~32'h7F) | $urandom_range(0, 23);
        else k = $urandom();
        send_request(CMD_INSERT, k, $urandom());
      end else begin
        if (r < 4) k = pool_key();
        else if (r < 7) k = pool_key() ^ ($urandom() & ~32'h7F);
        else k = $urandom();
        send_request(CMD_LOOKUP, k, $urandom());
      end
    end
    req.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int mode;
    int phase_len;
    int hold_at;
    rsp.ready <= 1'b0;
    hold_at = 30;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (items_sent >= hold_at) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_at += 650;
      end
      mode      = $urandom_range(0, 3);
      phase_len = $urandom_range(5, 60);
      repeat (phase_len) begin
        case (mode)
          0: begin
            rsp.ready <= 1'b1;
          end
          1: begin
            rsp.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            rsp.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            rsp.ready <= ($urandom_range(0, 7) != 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
src/lpht_pkg.sv
src/lpht_if.sv
src/lpht_store.sv
src/linear_probe_hash_table_unit.sv
src/lpht_checker.sv
dv/lpht_checker.sv
dv/tb_top.sv
